### rtl/core/cisu_pkg.sv
// cisu_pkg: shared types, constants and arithmetic helpers of the cnn input standardize core
package cisu_pkg;

    // geometry
    localparam int IMAGE_ROWS     = 168;
    localparam int IMAGE_COLS     = 168;
    localparam int DEPTH_SIDE     = 8;
    localparam int UPSAMPLED_SIDE = 21;

    localparam int FRAME_PIXELS = IMAGE_ROWS * IMAGE_COLS;
    localparam int DEPTH_CELLS  = DEPTH_SIDE * DEPTH_SIDE;
    localparam int DEPTH_ADDR_W = $clog2(DEPTH_CELLS);
    localparam int SIDE_W       = $clog2(DEPTH_SIDE);

    // reciprocal of the upsampled side for the nearest-neighbor source coordinate
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + UPSAMPLED_SIDE - 1) / UPSAMPLED_SIDE;

    // field widths
    localparam int MODE_W    = 2;
    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 15;
    localparam int COORD_W   = 5;
    localparam int VALUE_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    localparam int IMG_MEAN_W  = 17;
    localparam int IMG_GAIN_W  = 10;
    localparam int DEP_MEAN_W  = 20;
    localparam int DEP_GAIN_W  = 16;
    localparam int DEP_MAG_W   = 21;
    localparam int DEP_PROD_W  = DEP_MAG_W + DEP_GAIN_W;
    localparam int DEP_FRAC    = 20;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_PIXEL       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEPTH_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEPTH_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_MEAN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MEAN_TENTHS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN_SECOND = 3'd4;

    // register reset values
    localparam logic [IMG_MEAN_W-1:0] IMAGE_MEAN_RST        = 17'd26517;
    localparam logic [IMG_GAIN_W-1:0] IMAGE_GAIN_RST        = 10'd320;
    localparam logic [DEP_MEAN_W-1:0] DEPTH_MEAN_TENTHS_RST = 20'd27159;
    localparam logic [DEP_GAIN_W-1:0] DEPTH_GAIN_FIRST_RST  = 16'd5363;
    localparam logic [DEP_GAIN_W-1:0] DEPTH_GAIN_SECOND_RST = 16'd5473;

    typedef struct packed {
        logic [IMG_MEAN_W-1:0] image_mean;
        logic [IMG_GAIN_W-1:0] image_gain;
        logic [DEP_MEAN_W-1:0] depth_mean_tenths;
        logic [DEP_GAIN_W-1:0] depth_gain_first;
        logic [DEP_GAIN_W-1:0] depth_gain_second;
    } cisu_cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]  position;
        logic [COORD_W-1:0]  out_row;
        logic [COORD_W-1:0]  out_col;
    } cisu_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        dest_index;
        logic signed [VALUE_W-1:0] first_value;
        logic signed [VALUE_W-1:0] second_value;
        logic                      clipped;
    } cisu_result_t;

    typedef struct packed {
        logic                    wr_en;
        logic [DEPTH_ADDR_W-1:0] wr_addr;
        logic                    rd_en;
        logic [DEPTH_ADDR_W-1:0] rd_addr;
    } cisu_store_ctl_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               sat;
    } cisu_quant_t;

    // round magnitude product by 2^20 half away from zero, apply sign, saturate to int8
    function automatic cisu_quant_t depth_quant(input logic [DEP_PROD_W-1:0] prod,
                                                input logic neg);
        logic [DEP_PROD_W:0]            rounded;
        logic [DEP_PROD_W-DEP_FRAC:0]   q;
        cisu_quant_t                    res;
        rounded = {1'b0, prod} + (DEP_PROD_W+1)'(1 << (DEP_FRAC - 1));
        q       = rounded[DEP_PROD_W:DEP_FRAC];
        res.sat = 1'b0;
        if (neg) begin
            if (q > (DEP_PROD_W-DEP_FRAC+1)'(128)) begin
                res.sat   = 1'b1;
                res.value = 8'h80;
            end
            else begin
                res.value = 8'(0 - q[VALUE_W-1:0]);
            end
        end
        else begin
            if (q > (DEP_PROD_W-DEP_FRAC+1)'(127)) begin
                res.sat   = 1'b1;
                res.value = 8'h7F;
            end
            else begin
                res.value = q[VALUE_W-1:0];
            end
        end
        return res;
    endfunction

    // source coordinate of nearest-neighbor upsampling, coord*DEPTH_SIDE/UPSAMPLED_SIDE
    function automatic logic [SIDE_W-1:0] src_coord(input logic [COORD_W-1:0] coord);
        logic [31:0] scaled;
        scaled = 32'(coord) * 32'(DEPTH_SIDE) * 32'(RECIP_MULT);
        return scaled[RECIP_SHIFT +: SIDE_W];
    endfunction

endpackage

### rtl/core/cisu_datapath.sv
// cisu_datapath: per-beat arithmetic for pixel quantize, depth quantize and upsample addressing
module cisu_datapath
    import cisu_pkg::*;
(
    input  cisu_cfg_t       cfg,
    input  cisu_item_t      item,
    output cisu_result_t    result,
    output cisu_store_ctl_t store_ctl
);

    logic signed [IMG_MEAN_W+1:0]                pix_diff;
    logic signed [IMG_MEAN_W+IMG_GAIN_W+2:0]     pix_prod;
    logic [VALUE_W-1:0]                          pix_value;
    logic [INDEX_W-1:0]                          pix_dest;

    logic [DEP_MEAN_W-1:0]                       dep_scaled;
    logic signed [DEP_MEAN_W+1:0]                dep_diff;
    logic                                        dep_neg;
    logic [DEP_MAG_W-1:0]                        dep_mag;
    logic [DEP_PROD_W-1:0]                       dep_prod_first;
    logic [DEP_PROD_W-1:0]                       dep_prod_second;
    cisu_quant_t                                 quant_first;
    cisu_quant_t                                 quant_second;

    logic [COORD_W-1:0]                          row_sat;
    logic [COORD_W-1:0]                          col_sat;
    logic [SIDE_W-1:0]                           src_row;
    logic [SIDE_W-1:0]                           src_col;
    logic [31:0]                                 up_dest;
    logic [31:0]                                 src_addr;

    // pixel: (p*512 - mean)*gain + 2^17, floor by 2^18, keep low byte
    assign pix_diff  = $signed({2'b00, item.sample[7:0], 9'd0})
                     - $signed({2'b00, cfg.image_mean});
    assign pix_prod  = pix_diff * $signed({1'b0, cfg.image_gain})
                     + $signed((IMG_MEAN_W+IMG_GAIN_W+3)'(1 << 17));
    assign pix_value = pix_prod[25:18];
    assign pix_dest  = (32'(item.position) < 32'(FRAME_PIXELS))
                     ? INDEX_W'(32'(FRAME_PIXELS - 1) - 32'(item.position))
                     : '0;

    // depth: sample*10 - mean in tenths, sign and magnitude
    assign dep_scaled = DEP_MEAN_W'(item.sample) * DEP_MEAN_W'(10);
    assign dep_diff   = $signed({2'b00, dep_scaled}) - $signed({2'b00, cfg.depth_mean_tenths});
    assign dep_neg    = dep_diff[DEP_MEAN_W+1];
    assign dep_mag    = dep_neg ? DEP_MAG_W'(-dep_diff) : DEP_MAG_W'(dep_diff);

    assign dep_prod_first  = dep_mag * cfg.depth_gain_first;
    assign dep_prod_second = dep_mag * cfg.depth_gain_second;
    assign quant_first     = depth_quant(dep_prod_first, dep_neg);
    assign quant_second    = depth_quant(dep_prod_second, dep_neg);

    // upsample: clamp coordinates, map to source cell
    assign row_sat  = (32'(item.out_row) < 32'(UPSAMPLED_SIDE))
                    ? item.out_row : COORD_W'(UPSAMPLED_SIDE - 1);
    assign col_sat  = (32'(item.out_col) < 32'(UPSAMPLED_SIDE))
                    ? item.out_col : COORD_W'(UPSAMPLED_SIDE - 1);
    assign src_row  = src_coord(row_sat);
    assign src_col  = src_coord(col_sat);
    assign src_addr = 32'(src_row) * 32'(DEPTH_SIDE) + 32'(src_col);
    assign up_dest  = 32'(row_sat) * 32'(UPSAMPLED_SIDE) + 32'(col_sat);

    // store access
    assign store_ctl.wr_en   = (item.mode == MODE_DEPTH_WRITE)
                            && (32'(item.position) < 32'(DEPTH_CELLS));
    assign store_ctl.wr_addr = item.position[DEPTH_ADDR_W-1:0];
    assign store_ctl.rd_en   = (item.mode == MODE_DEPTH_READ);
    assign store_ctl.rd_addr = src_addr[DEPTH_ADDR_W-1:0];

    // result select per mode; upsample values come from the store
    always_comb
    begin
        result = '0;
        case (item.mode)
            MODE_PIXEL:
            begin
                result.dest_index   = pix_dest;
                result.first_value  = pix_value;
                result.second_value = pix_value;
            end
            MODE_DEPTH_WRITE:
            begin
                result.dest_index   = item.position;
                result.first_value  = quant_first.value;
                result.second_value = quant_second.value;
                result.clipped      = quant_first.sat | quant_second.sat;
            end
            MODE_DEPTH_READ:
            begin
                result.dest_index   = up_dest[INDEX_W-1:0];
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

### rtl/core/cnn_input_standardize_upsample_core.sv
// cnn_input_standardize_upsample_core: input register, arithmetic, depth store and output register
//
// Use: items enter on the in channel (mode, sample, position, out_row, out_col) with
// in_valid/in_ready; one result per item leaves on the out channel (dest_index,
// first_value, second_value, clipped) with out_valid/out_ready, in item order.
// Mode 0 quantizes a pixel and returns its 180-degree flipped index, mode 1
// quantizes a depth sample for both networks and stores it in the 8x8 grid,
// mode 2 reads back the grid cell picked by nearest-neighbor upsampling to 21x21.
// Registers are written on the cfg channel (cfg_index, cfg_data), always ready;
// write them only while no item is in flight.
// An accepted input beat passes the input register, then the output register, to the
// result beat. Throughput: one item per cycle while out_ready is high, set by the single
// pass through the input register, the 21x16 depth multipliers and the output register;
// the depth store is read and written once per cycle at the output register edge.
// Reset: registers return to their reset values, both stages empty; the depth
// store is not cleared and a grid cell must be written before it is read.
// Stall: while out_ready is low the result holds, one more item is taken into the
// input register, then in_ready drops until the result beat leaves.
module cnn_input_standardize_upsample_core
    import cisu_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [MODE_W-1:0]           mode,
    input  logic [SAMPLE_W-1:0]         sample,
    input  logic [INDEX_W-1:0]          position,
    input  logic [COORD_W-1:0]          out_row,
    input  logic [COORD_W-1:0]          out_col,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [INDEX_W-1:0]          dest_index,
    output logic signed [VALUE_W-1:0]   first_value,
    output logic signed [VALUE_W-1:0]   second_value,
    output logic                        clipped
);

    cisu_cfg_t          cfg_reg;
    logic               in_valid_reg;
    cisu_item_t         item_reg;
    logic               out_valid_reg;
    cisu_result_t       res_reg;
    cisu_result_t       res_next;
    cisu_store_ctl_t    store_ctl;
    logic               advance;
    logic               in_take;

    logic [VALUE_W-1:0] store_first  [DEPTH_CELLS];
    logic [VALUE_W-1:0] store_second [DEPTH_CELLS];

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.image_mean        <= IMAGE_MEAN_RST;
            cfg_reg.image_gain        <= IMAGE_GAIN_RST;
            cfg_reg.depth_mean_tenths <= DEPTH_MEAN_TENTHS_RST;
            cfg_reg.depth_gain_first  <= DEPTH_GAIN_FIRST_RST;
            cfg_reg.depth_gain_second <= DEPTH_GAIN_SECOND_RST;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IMAGE_MEAN:        cfg_reg.image_mean        <= cfg_data[IMG_MEAN_W-1:0];
                REG_IMAGE_GAIN:        cfg_reg.image_gain        <= cfg_data[IMG_GAIN_W-1:0];
                REG_DEPTH_MEAN_TENTHS: cfg_reg.depth_mean_tenths <= cfg_data[DEP_MEAN_W-1:0];
                REG_DEPTH_GAIN_FIRST:  cfg_reg.depth_gain_first  <= cfg_data[DEP_GAIN_W-1:0];
                REG_DEPTH_GAIN_SECOND: cfg_reg.depth_gain_second <= cfg_data[DEP_GAIN_W-1:0];
                default:               ;
            endcase
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end
            else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            item_reg.mode     <= mode;
            item_reg.sample   <= sample;
            item_reg.position <= position;
            item_reg.out_row  <= out_row;
            item_reg.out_col  <= out_col;
        end
    end

    cisu_datapath u_datapath (
        .cfg       (cfg_reg),
        .item      (item_reg),
        .result    (res_next),
        .store_ctl (store_ctl)
    );

    // depth store write
    always_ff @(posedge clk)
    begin
        if (advance && store_ctl.wr_en) begin
            store_first[store_ctl.wr_addr]  <= res_next.first_value;
            store_second[store_ctl.wr_addr] <= res_next.second_value;
        end
    end

    // output register, upsample values read from the store here
    always_ff @(posedge clk)
    begin
        if (advance) begin
            res_reg.dest_index <= res_next.dest_index;
            res_reg.clipped    <= res_next.clipped;
            if (store_ctl.rd_en) begin
                res_reg.first_value  <= store_first[store_ctl.rd_addr];
                res_reg.second_value <= store_second[store_ctl.rd_addr];
            end
            else begin
                res_reg.first_value  <= res_next.first_value;
                res_reg.second_value <= res_next.second_value;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_index   = res_reg.dest_index;
    assign first_value  = res_reg.first_value;
    assign second_value = res_reg.second_value;
    assign clipped      = res_reg.clipped;

`ifndef SYNTHESIS
    // input stage only blocks while it holds an item
    assert property (@(posedge clk) disable iff (!rst_n) !in_ready |-> in_valid_reg)
        else $error("in_ready low with empty input stage");

    // a held item moves to the output when the output stage is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("item lost between stages");

    // a clipped result carries a saturated value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.clipped) |->
            (res_reg.first_value == 8'sh7F || res_reg.first_value == -8'sd128 ||
             res_reg.second_value == 8'sh7F || res_reg.second_value == -8'sd128))
        else $error("clipped set without saturated value");

    // pixel results carry the same value for both networks
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.mode == MODE_PIXEL) |=>
            (res_reg.first_value == res_reg.second_value && !res_reg.clipped))
        else $error("pixel result mismatch");
`endif

endmodule

### bench/cnn_input_standardize_upsample_core_tb.sv
// testbench for cnn_input_standardize_upsample_core: random and directed beats checked against a predictor
`timescale 1ns / 100ps

module cnn_input_standardize_upsample_core_tb;
    import cisu_pkg::*;

    // mode code the block leaves unused, and the register indexes past the last register
    localparam logic [MODE_W-1:0]    MODE_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = REG_DEPTH_GAIN_SECOND + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = '1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DAT_W-1:0]      cfg_data = '0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [MODE_W-1:0]         mode = '0;
    logic [SAMPLE_W-1:0]       sample = '0;
    logic [INDEX_W-1:0]        position = '0;
    logic [COORD_W-1:0]        out_row = '0;
    logic [COORD_W-1:0]        out_col = '0;

    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [INDEX_W-1:0]        dest_index;
    logic signed [VALUE_W-1:0] first_value;
    logic signed [VALUE_W-1:0] second_value;
    logic                      clipped;

    // register copies held by the predictor
    logic [IMG_MEAN_W-1:0] img_mean  = IMAGE_MEAN_RST;
    logic [IMG_GAIN_W-1:0] img_gain  = IMAGE_GAIN_RST;
    logic [DEP_MEAN_W-1:0] dep_mean  = DEPTH_MEAN_TENTHS_RST;
    logic [DEP_GAIN_W-1:0] dep_gain1 = DEPTH_GAIN_FIRST_RST;
    logic [DEP_GAIN_W-1:0] dep_gain2 = DEPTH_GAIN_SECOND_RST;

    // predicted depth grids for both networks
    logic [VALUE_W-1:0] grid_first [DEPTH_CELLS];
    logic [VALUE_W-1:0] grid_second [DEPTH_CELLS];

    // grid cells already written by queued beats, so reads never hit empty cells
    logic [DEPTH_CELLS-1:0] cells_filled = '0;

    cisu_item_t   items_to_send[$];
    cisu_result_t standardized_due[$];
    cisu_item_t   sent_item;

    int error_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_tick = 0;

    cnn_input_standardize_upsample_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .sample       (sample),
        .position     (position),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dest_index   (dest_index),
        .first_value  (first_value),
        .second_value (second_value),
        .clipped      (clipped)
    );

    always #2 clk = ~clk;

    // grid cell that nearest-neighbor upsampling reads for an output row and column
    function automatic int source_cell(input int row, input int col);
        int r;
        int c;
        r = (row < UPSAMPLED_SIDE) ? row : UPSAMPLED_SIDE - 1;
        c = (col < UPSAMPLED_SIDE) ? col : UPSAMPLED_SIDE - 1;
        return (r * DEPTH_SIDE / UPSAMPLED_SIDE) * DEPTH_SIDE + c * DEPTH_SIDE / UPSAMPLED_SIDE;
    endfunction

    // diff*gain/2^20 rounded half away from zero, saturated; returns {sat, value}
    function automatic logic [VALUE_W:0] round_depth(input longint diff,
                                                     input logic [DEP_GAIN_W-1:0] gain);
        longint mag;
        longint q;
        mag = ((diff < 0) ? -diff : diff) * longint'(gain);
        q = (mag + (longint'(1) <<< 19)) >>> 20;
        if (diff < 0)
        begin
            if (q > 128)
                return {1'b1, 8'h80};
            return {1'b0, 8'(-q)};
        end
        if (q > 127)
            return {1'b1, 8'h7F};
        return {1'b0, q[7:0]};
    endfunction

    // expected result of one accepted beat; depth writes update the predicted grids
    function automatic cisu_result_t standardize_item(input cisu_item_t it);
        cisu_result_t res;
        longint acc;
        longint diff;
        logic [VALUE_W:0] q_first;
        logic [VALUE_W:0] q_second;
        int r;
        int c;
        int src;
        res = '0;
        case (it.mode)
            MODE_PIXEL:
            begin
                acc = (longint'(it.sample[7:0]) * 512 - longint'(img_mean)) * longint'(img_gain)
                      + longint'(32'h20000);
                acc = acc >>> 18;
                res.first_value  = acc[7:0];
                res.second_value = acc[7:0];
                if (int'(it.position) < FRAME_PIXELS)
                    res.dest_index = INDEX_W'(FRAME_PIXELS - 1 - int'(it.position));
            end
            MODE_DEPTH_WRITE:
            begin
                diff = longint'(it.sample) * 10 - longint'(dep_mean);
                q_first  = round_depth(diff, dep_gain1);
                q_second = round_depth(diff, dep_gain2);
                if (int'(it.position) < DEPTH_CELLS)
                begin
                    grid_first[it.position]  = q_first[VALUE_W-1:0];
                    grid_second[it.position] = q_second[VALUE_W-1:0];
                end
                res.dest_index   = it.position;
                res.first_value  = q_first[VALUE_W-1:0];
                res.second_value = q_second[VALUE_W-1:0];
                res.clipped      = q_first[VALUE_W] | q_second[VALUE_W];
            end
            MODE_DEPTH_READ:
            begin
                r = (it.out_row < UPSAMPLED_SIDE) ? int'(it.out_row) : UPSAMPLED_SIDE - 1;
                c = (it.out_col < UPSAMPLED_SIDE) ? int'(it.out_col) : UPSAMPLED_SIDE - 1;
                src = source_cell(r, c);
                res.first_value  = grid_first[src];
                res.second_value = grid_second[src];
                res.dest_index   = INDEX_W'(r * UPSAMPLED_SIDE + c);
            end
            default:
            begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (error_count < PRINT_CAP)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     results_seen, what, want, got);
        error_count++;
    endtask

    task automatic queue_item(input logic [MODE_W-1:0] m, input int s, input int p,
                              input int row, input int col);
        cisu_item_t it;
        it.mode     = m;
        it.sample   = SAMPLE_W'(s);
        it.position = INDEX_W'(p);
        it.out_row  = COORD_W'(row);
        it.out_col  = COORD_W'(col);
        if (m == MODE_DEPTH_WRITE && p < DEPTH_CELLS)
            cells_filled[p] = 1'b1;
        items_to_send.push_back(it);
    endtask

    // one register write beat; cfg_valid is left high for a following write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_IMAGE_MEAN:        img_mean  = data[IMG_MEAN_W-1:0];
            REG_IMAGE_GAIN:        img_gain  = data[IMG_GAIN_W-1:0];
            REG_DEPTH_MEAN_TENTHS: dep_mean  = data[DEP_MEAN_W-1:0];
            REG_DEPTH_GAIN_FIRST:  dep_gain1 = data[DEP_GAIN_W-1:0];
            REG_DEPTH_GAIN_SECOND: dep_gain2 = data[DEP_GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DAT_W-1:0] mean_v, input logic [CFG_DAT_W-1:0] gain_v,
                             input logic [CFG_DAT_W-1:0] dmean_v,
                             input logic [CFG_DAT_W-1:0] g1_v, input logic [CFG_DAT_W-1:0] g2_v,
                             input bit touch_spare);
        logic [CFG_IDX_W-1:0] idx;
        write_register(REG_IMAGE_MEAN, mean_v);
        write_register(REG_IMAGE_GAIN, gain_v);
        write_register(REG_DEPTH_MEAN_TENTHS, dmean_v);
        write_register(REG_DEPTH_GAIN_FIRST, g1_v);
        write_register(REG_DEPTH_GAIN_SECOND, g2_v);
        // indexes with no register behind them must change nothing
        if (touch_spare)
        begin
            idx = REG_SPARE_LOW;
            forever
            begin
                write_register(idx, CFG_DAT_W'($urandom));
                if (idx == REG_SPARE_TOP)
                    break;
                idx++;
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // pause the sender until every beat is through and every result is back;
    // the idle state must hold on consecutive edges, since a beat popped by the
    // driver on an edge only shows on in_valid after that edge
    task automatic wait_for_drain();
        int quiet;
        quiet = 0;
        while (quiet < 2)
        begin
            @(posedge clk);
            if (items_to_send.size() != 0 || in_valid || standardized_due.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    // extremes of every field and each corner case, under reset settings
    task automatic queue_directed_items();
        queue_item(MODE_DEPTH_WRITE, 0, 0, 0, 0);
        queue_item(MODE_DEPTH_WRITE, 65535, DEPTH_CELLS - 1, 0, 0);
        queue_item(MODE_DEPTH_WRITE, 2716, DEPTH_SIDE - 1, 0, 0);
        queue_item(MODE_DEPTH_WRITE, 2500, DEPTH_CELLS - DEPTH_SIDE, 0, 0);
        // depth index past the grid: returned but not stored
        queue_item(MODE_DEPTH_WRITE, 3000, DEPTH_CELLS, 0, 0);
        queue_item(MODE_DEPTH_WRITE, 1234, 32767, 0, 0);
        queue_item(MODE_PIXEL, 0, 0, 0, 0);
        queue_item(MODE_PIXEL, 255, FRAME_PIXELS - 1, 0, 0);
        // upper sample bits ignored, pixel index past the frame
        queue_item(MODE_PIXEL, 256, FRAME_PIXELS, 0, 0);
        queue_item(MODE_PIXEL, 65535, 32767, 31, 31);
        queue_item(MODE_DEPTH_READ, 0, 0, 0, 0);
        queue_item(MODE_DEPTH_READ, 0, 0, UPSAMPLED_SIDE - 1, UPSAMPLED_SIDE - 1);
        // row and column past the upsampled grid saturate
        queue_item(MODE_DEPTH_READ, 65535, 32767, 31, 31);
        queue_item(MODE_DEPTH_READ, 0, 0, 0, 31);
        queue_item(MODE_DEPTH_READ, 0, 0, 31, 0);
        queue_item(MODE_DEPTH_READ, 0, 0, UPSAMPLED_SIDE - 1, 0);
        queue_item(MODE_UNUSED, 65535, 32767, 31, 31);
        queue_item(MODE_UNUSED, 0, 0, 0, 0);
    endtask

    task automatic queue_random_items(input int count);
        int pick;
        int s;
        int p;
        int row;
        int col;
        int center;
        int spread;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            s   = $urandom_range(0, 65535);
            p   = $urandom_range(0, 32767);
            row = $urandom_range(0, 31);
            col = $urandom_range(0, 31);
            if (pick < 33)
            begin
                if ($urandom_range(0, 9) < 7)
                    s = $urandom_range(0, 255);
                if ($urandom_range(0, 9) < 8)
                    p = $urandom_range(0, FRAME_PIXELS - 1);
                queue_item(MODE_PIXEL, s, p, row, col);
            end
            else if (pick < 95 && (pick < 66 || cells_filled == '0))
            begin
                // mostly near the mean so rounding is exercised, sometimes anywhere
                if ($urandom_range(0, 3) != 0)
                begin
                    center = int'(dep_mean) / 10;
                    spread = ($urandom_range(0, 3) == 0) ? 1500 : 150;
                    s = center + $urandom_range(0, 2 * spread) - spread;
                    s = (s < 0) ? 0 : (s > 65535) ? 65535 : s;
                end
                if ($urandom_range(0, 99) < 85)
                    p = $urandom_range(0, DEPTH_CELLS - 1);
                queue_item(MODE_DEPTH_WRITE, s, p, row, col);
            end
            else if (pick < 95)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    row = $urandom_range(0, UPSAMPLED_SIDE - 1);
                    col = $urandom_range(0, UPSAMPLED_SIDE - 1);
                end
                // fill the cell first rather than read an empty one
                if (!cells_filled[source_cell(row, col)])
                    queue_item(MODE_DEPTH_WRITE, s, source_cell(row, col), row, col);
                else
                    queue_item(MODE_DEPTH_READ, s, p, row, col);
            end
            else
            begin
                queue_item(MODE_UNUSED, s, p, row, col);
            end
        end
    endtask

    // driver: bursts of beats with random gaps, prediction on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                standardized_due.push_back(standardize_item(sent_item));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (items_to_send.size() != 0)
                begin
                    sent_item = items_to_send.pop_front();
                    mode     <= sent_item.mode;
                    sample   <= sent_item.sample;
                    position <= sent_item.position;
                    out_row  <= sent_item.out_row;
                    out_col  <= sent_item.out_col;
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat, stall the output on a rotating pattern
    always @(posedge clk or negedge rst_n)
    begin
        cisu_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (standardized_due.size() == 0)
                begin
                    report_mismatch("result with nothing due", 0, int'(dest_index));
                end
                else
                begin
                    want = standardized_due.pop_front();
                    if (dest_index !== want.dest_index)
                        report_mismatch("dest_index", int'(want.dest_index), int'(dest_index));
                    if (first_value !== want.first_value)
                        report_mismatch("first_value", int'(want.first_value),
                                        int'(first_value));
                    if (second_value !== want.second_value)
                        report_mismatch("second_value", int'(want.second_value),
                                        int'(second_value));
                    if (clipped !== want.clipped)
                        report_mismatch("clipped", int'(want.clipped), int'(clipped));
                end
                results_seen++;
            end
            stall_tick++;
            case ((stall_tick >> 8) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 7) != 0);
                default: out_ready <= ((stall_tick % 16) >= 11);
            endcase
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // phases: reset settings, all zero, all high, rounding ties, then random settings
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_directed_items();
        queue_random_items(100);
        wait_for_drain();

        configure('0, '0, '0, '0, '0, 1'b1);
        queue_random_items(90);
        wait_for_drain();

        configure(20'd131071, 20'd1023, 20'd655350, 20'd65535, 20'd65535, 1'b0);
        queue_random_items(90);
        wait_for_drain();

        // gains of 2^12 and 2^15 land many depth products exactly on a half
        configure(20'd65536, 20'd512, 20'd1280, 20'd4096, 20'd32768, 1'b0);
        queue_random_items(90);
        wait_for_drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            configure(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
                      CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), 1'b1);
            queue_random_items(80);
            wait_for_drain();
        end

        // let any stray beat show before the verdict
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
